// File: design/periodic_poll_timing_wheel_top_defines.svh
// Assertion macros for the periodic poll timing wheel.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef PERIODIC_POLL_TIMING_WHEEL_TOP_DEFINES_SVH
`define PERIODIC_POLL_TIMING_WHEEL_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define PPTW_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("pptw assertion failed");
`define PPTW_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("pptw forbidden condition seen");
`else
`define PPTW_ASSERT(label, clk, rst_n, prop)
`define PPTW_NEVER(label, clk, rst_n, expr)
`endif

`endif

// File: design/pptw_pkg.sv
// Shared constants, codes and types for the periodic poll timing wheel.
// No dependencies; used by pptw_front, pptw_back and the top level.
package pptw_pkg;

    localparam int SLOT_COUNT    = 10;
    localparam int ATOM_MS       = 25;
    localparam int MAX_PERIOD_MS = 256;
    localparam int ENDPOINTS     = 16;

    localparam int CMD_W      = 2;
    localparam int EP_W       = 5;
    localparam int PERIOD_W   = 10;
    localparam int KIND_W     = 3;
    localparam int SLOT_OUT_W = 4;

    localparam int SLOT_W  = $clog2(SLOT_COUNT);
    localparam int PER_W   = $clog2(SLOT_COUNT + 1);
    localparam int IDX_W   = (ENDPOINTS > 1) ? $clog2(ENDPOINTS) : 1;
    localparam int GUARD_W = $clog2(ENDPOINTS + 1);

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef enum logic [CMD_W-1:0] {
        CMD_START = 2'd0,
        CMD_TICK  = 2'd1,
        CMD_STOP  = 2'd2
    } cmd_t;

    typedef enum logic [KIND_W-1:0] {
        K_CHECK   = 3'd0,
        K_POLL    = 3'd1,
        K_STARTED = 3'd2,
        K_REJECT  = 3'd3,
        K_DONE    = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        OP_START,
        OP_REJECT,
        OP_TICK,
        OP_STOP
    } op_t;

    typedef struct packed {
        op_t              op;
        logic [EP_W-1:0]  ep;
        logic [PER_W-1:0] slots;
    } q_item_t;

    // ceil(period / ATOM_MS), capped at SLOT_COUNT; period is nonzero here
    function automatic logic [PER_W-1:0] period_to_slots(input logic [PERIOD_W-1:0] period);
        logic [PER_W-1:0] s;
        s = PER_W'(1);
        for (int k = 1; k < SLOT_COUNT; k++)
        begin
            if (32'(period) > k * ATOM_MS)
            begin
                s = PER_W'(k + 1);
            end
        end
        return s;
    endfunction

endpackage

// File: design/pptw_front.sv
// Front end: decodes and validates incoming transactions and queues them.
// Depends on pptw_pkg and periodic_poll_timing_wheel_top_defines.svh.
`include "periodic_poll_timing_wheel_top_defines.svh"

module pptw_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [pptw_pkg::CMD_W-1:0]    cmd,
    input  logic [pptw_pkg::EP_W-1:0]     endpoint,
    input  logic [pptw_pkg::PERIOD_W-1:0] period_ms,
    input  logic [pptw_pkg::EP_W-1:0]     ep_count,
    output logic                          q_valid,
    output pptw_pkg::q_item_t             q_item,
    input  logic                          q_pop
);

    pptw_pkg::q_item_t              item_s;
    logic                           keep_s;
    logic                           ep_ok_s;
    logic                           per_ok_s;
    logic                           push_s;

    pptw_pkg::q_item_t              q_mem_reg [pptw_pkg::Q_DEPTH];
    logic [pptw_pkg::Q_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [pptw_pkg::Q_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [pptw_pkg::Q_CNT_W-1:0]   count_reg, count_next;

    always_comb
    begin
        ep_ok_s  = (endpoint != '0) && (endpoint <= ep_count)
                   && (32'(endpoint) <= pptw_pkg::ENDPOINTS);
        per_ok_s = (period_ms != '0) && (32'(period_ms) <= pptw_pkg::MAX_PERIOD_MS);
        item_s.op    = pptw_pkg::OP_REJECT;
        item_s.ep    = endpoint;
        item_s.slots = pptw_pkg::period_to_slots(period_ms);
        keep_s       = 1'b0;
        unique case (cmd)
            pptw_pkg::CMD_START:
            begin
                keep_s    = 1'b1;
                item_s.op = (ep_ok_s && per_ok_s) ? pptw_pkg::OP_START : pptw_pkg::OP_REJECT;
            end
            pptw_pkg::CMD_TICK:
            begin
                keep_s    = 1'b1;
                item_s.op = pptw_pkg::OP_TICK;
            end
            pptw_pkg::CMD_STOP:
            begin
                keep_s    = ep_ok_s;
                item_s.op = pptw_pkg::OP_STOP;
            end
            default:
            begin
                keep_s = 1'b0;
            end
        endcase
    end

    assign in_ready = (count_reg != pptw_pkg::Q_CNT_W'(pptw_pkg::Q_DEPTH));
    assign push_s   = in_valid && in_ready && keep_s;
    assign q_valid  = (count_reg != '0);
    assign q_item   = q_mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push_s)
        begin
            wr_ptr_next = (wr_ptr_reg == pptw_pkg::Q_PTR_W'(pptw_pkg::Q_DEPTH - 1))
                          ? '0 : wr_ptr_reg + 1'b1;
        end
        if (q_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == pptw_pkg::Q_PTR_W'(pptw_pkg::Q_DEPTH - 1))
                          ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push_s && !q_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push_s && q_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_s)
        begin
            q_mem_reg[wr_ptr_reg] <= item_s;
        end
    end

    `PPTW_NEVER(a_count_range, clk, rst_n, 32'(count_reg) > pptw_pkg::Q_DEPTH)
    `PPTW_ASSERT(a_pop_nonempty, clk, rst_n, q_pop |-> count_reg != '0)
    `PPTW_NEVER(a_no_overflow, clk, rst_n, push_s && !q_pop && !in_ready)

endmodule

// File: design/pptw_back.sv
// Back end: owns the wheel state, runs start/stop updates and the tick list walk,
// and holds the result register. Depends on pptw_pkg and the defines header.
`include "periodic_poll_timing_wheel_top_defines.svh"

module pptw_back (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            q_valid,
    input  pptw_pkg::q_item_t               q_item,
    output logic                            q_pop,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [pptw_pkg::KIND_W-1:0]     kind,
    output logic [pptw_pkg::EP_W-1:0]       endpoint_out,
    output logic [pptw_pkg::SLOT_OUT_W-1:0] slot_out,
    output logic                            last
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_MOVE
    } state_t;

    localparam int SUM_W = pptw_pkg::SLOT_W + 1;

    state_t                              state_reg, state_next;
    logic [pptw_pkg::SLOT_W-1:0]         pos_reg, pos_next;
    logic [pptw_pkg::EP_W-1:0]           cur_reg, cur_next;
    logic [pptw_pkg::EP_W-1:0]           prev_reg, prev_next;
    logic [pptw_pkg::GUARD_W-1:0]        guard_reg, guard_next;
    logic [pptw_pkg::EP_W-1:0]           mv_ep_reg, mv_ep_next;
    logic [pptw_pkg::SLOT_W-1:0]         mv_dest_reg, mv_dest_next;

    logic                                out_valid_reg;
    pptw_pkg::kind_t                     kind_reg;
    logic [pptw_pkg::EP_W-1:0]           ep_out_reg;
    logic [pptw_pkg::SLOT_OUT_W-1:0]     slot_reg;
    logic                                last_reg;

    logic [pptw_pkg::EP_W-1:0]           head_reg  [pptw_pkg::SLOT_COUNT];
    logic [pptw_pkg::EP_W-1:0]           link_reg  [pptw_pkg::ENDPOINTS];
    logic [pptw_pkg::PER_W-1:0]          per_reg   [pptw_pkg::ENDPOINTS];
    logic [pptw_pkg::ENDPOINTS-1:0]      queued_reg;
    logic [pptw_pkg::ENDPOINTS-1:0]      stop_reg;

    logic                                out_free_s;
    logic                                emit_s;
    pptw_pkg::kind_t                     emit_kind_s;
    logic [pptw_pkg::EP_W-1:0]           emit_ep_s;
    logic                                emit_last_s;

    logic [pptw_pkg::IDX_W-1:0]          ep_idx_s, cur_idx_s, prev_idx_s, mv_idx_s;
    logic [pptw_pkg::SLOT_W-1:0]         pos_plus1_s, dest_s, head_raddr_s;
    logic [SUM_W-1:0]                    sum_s;
    logic [pptw_pkg::EP_W-1:0]           head_rdata_s, link_rdata_s;
    logic [pptw_pkg::PER_W-1:0]          per_cur_s;
    logic                                walk_end_s;

    logic                                head_we_s;
    logic [pptw_pkg::SLOT_W-1:0]         head_waddr_s;
    logic [pptw_pkg::EP_W-1:0]           head_wdata_s;
    logic                                link_we_s;
    logic [pptw_pkg::IDX_W-1:0]          link_waddr_s;
    logic [pptw_pkg::EP_W-1:0]           link_wdata_s;
    logic                                ins_we_s, stop_we_s, clr_we_s;

    assign out_free_s = !out_valid_reg || out_ready;

    assign ep_idx_s   = pptw_pkg::IDX_W'(q_item.ep - 1'b1);
    assign cur_idx_s  = pptw_pkg::IDX_W'(cur_reg - 1'b1);
    assign prev_idx_s = pptw_pkg::IDX_W'(prev_reg - 1'b1);
    assign mv_idx_s   = pptw_pkg::IDX_W'(mv_ep_reg - 1'b1);

    assign pos_plus1_s = (pos_reg == pptw_pkg::SLOT_W'(pptw_pkg::SLOT_COUNT - 1))
                         ? '0 : pos_reg + 1'b1;

    assign per_cur_s = per_reg[cur_idx_s];
    assign sum_s     = SUM_W'(pos_reg) + SUM_W'(per_cur_s);
    assign dest_s    = (sum_s >= SUM_W'(pptw_pkg::SLOT_COUNT))
                       ? pptw_pkg::SLOT_W'(sum_s - SUM_W'(pptw_pkg::SLOT_COUNT))
                       : pptw_pkg::SLOT_W'(sum_s);

    always_comb
    begin
        if (state_reg == ST_MOVE)
        begin
            head_raddr_s = mv_dest_reg;
        end
        else if (q_item.op == pptw_pkg::OP_TICK)
        begin
            head_raddr_s = pos_reg;
        end
        else
        begin
            head_raddr_s = pos_plus1_s;
        end
    end

    assign head_rdata_s = head_reg[head_raddr_s];
    assign link_rdata_s = link_reg[cur_idx_s];

    assign walk_end_s = (cur_reg == '0) || (32'(cur_reg) > pptw_pkg::ENDPOINTS)
                        || (guard_reg == pptw_pkg::GUARD_W'(pptw_pkg::ENDPOINTS));

    always_comb
    begin
        state_next   = state_reg;
        pos_next     = pos_reg;
        cur_next     = cur_reg;
        prev_next    = prev_reg;
        guard_next   = guard_reg;
        mv_ep_next   = mv_ep_reg;
        mv_dest_next = mv_dest_reg;
        q_pop        = 1'b0;
        emit_s       = 1'b0;
        emit_kind_s  = pptw_pkg::K_DONE;
        emit_ep_s    = '0;
        emit_last_s  = 1'b0;
        head_we_s    = 1'b0;
        head_waddr_s = pos_reg;
        head_wdata_s = '0;
        link_we_s    = 1'b0;
        link_waddr_s = cur_idx_s;
        link_wdata_s = '0;
        ins_we_s     = 1'b0;
        stop_we_s    = 1'b0;
        clr_we_s     = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    unique case (q_item.op)
                        pptw_pkg::OP_START:
                        begin
                            if (out_free_s)
                            begin
                                q_pop       = 1'b1;
                                emit_s      = 1'b1;
                                emit_last_s = 1'b1;
                                if (queued_reg[ep_idx_s])
                                begin
                                    emit_kind_s = pptw_pkg::K_REJECT;
                                end
                                else
                                begin
                                    emit_kind_s  = pptw_pkg::K_STARTED;
                                    emit_ep_s    = q_item.ep;
                                    ins_we_s     = 1'b1;
                                    head_we_s    = 1'b1;
                                    head_waddr_s = pos_plus1_s;
                                    head_wdata_s = q_item.ep;
                                    link_we_s    = 1'b1;
                                    link_waddr_s = ep_idx_s;
                                    link_wdata_s = head_rdata_s;
                                end
                            end
                        end
                        pptw_pkg::OP_REJECT:
                        begin
                            if (out_free_s)
                            begin
                                q_pop       = 1'b1;
                                emit_s      = 1'b1;
                                emit_kind_s = pptw_pkg::K_REJECT;
                                emit_last_s = 1'b1;
                            end
                        end
                        pptw_pkg::OP_STOP:
                        begin
                            q_pop     = 1'b1;
                            stop_we_s = queued_reg[ep_idx_s];
                        end
                        pptw_pkg::OP_TICK:
                        begin
                            if (out_free_s || pos_reg != '0)
                            begin
                                q_pop       = 1'b1;
                                emit_s      = (pos_reg == '0);
                                emit_kind_s = pptw_pkg::K_CHECK;
                                cur_next    = head_rdata_s;
                                prev_next   = '0;
                                guard_next  = '0;
                                state_next  = ST_WALK;
                            end
                        end
                        default:
                        begin
                            q_pop = 1'b1;
                        end
                    endcase
                end
            end
            ST_WALK:
            begin
                if (walk_end_s)
                begin
                    if (out_free_s)
                    begin
                        emit_s      = 1'b1;
                        emit_kind_s = pptw_pkg::K_DONE;
                        emit_last_s = 1'b1;
                        pos_next    = pos_plus1_s;
                        state_next  = ST_IDLE;
                    end
                end
                else if (stop_reg[cur_idx_s])
                begin
                    // stopped endpoint: unlink silently
                    if (prev_reg == '0)
                    begin
                        head_we_s    = 1'b1;
                        head_waddr_s = pos_reg;
                        head_wdata_s = link_rdata_s;
                    end
                    else
                    begin
                        link_we_s    = 1'b1;
                        link_waddr_s = prev_idx_s;
                        link_wdata_s = link_rdata_s;
                    end
                    clr_we_s   = 1'b1;
                    cur_next   = link_rdata_s;
                    guard_next = guard_reg + 1'b1;
                end
                else if (out_free_s)
                begin
                    emit_s      = 1'b1;
                    emit_kind_s = pptw_pkg::K_POLL;
                    emit_ep_s   = cur_reg;
                    cur_next    = link_rdata_s;
                    guard_next  = guard_reg + 1'b1;
                    if (32'(per_cur_s) < pptw_pkg::SLOT_COUNT)
                    begin
                        if (prev_reg == '0)
                        begin
                            head_we_s    = 1'b1;
                            head_waddr_s = pos_reg;
                            head_wdata_s = link_rdata_s;
                        end
                        else
                        begin
                            link_we_s    = 1'b1;
                            link_waddr_s = prev_idx_s;
                            link_wdata_s = link_rdata_s;
                        end
                        mv_ep_next   = cur_reg;
                        mv_dest_next = dest_s;
                        state_next   = ST_MOVE;
                    end
                    else
                    begin
                        prev_next = cur_reg;
                    end
                end
            end
            ST_MOVE:
            begin
                // push moved endpoint onto head of destination slot
                link_we_s    = 1'b1;
                link_waddr_s = mv_idx_s;
                link_wdata_s = head_rdata_s;
                head_we_s    = 1'b1;
                head_waddr_s = mv_dest_reg;
                head_wdata_s = mv_ep_reg;
                state_next   = ST_WALK;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pos_reg       <= '0;
            cur_reg       <= '0;
            prev_reg      <= '0;
            guard_reg     <= '0;
            mv_ep_reg     <= '0;
            mv_dest_reg   <= '0;
            out_valid_reg <= 1'b0;
            kind_reg      <= pptw_pkg::K_CHECK;
            ep_out_reg    <= '0;
            slot_reg      <= '0;
            last_reg      <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            pos_reg     <= pos_next;
            cur_reg     <= cur_next;
            prev_reg    <= prev_next;
            guard_reg   <= guard_next;
            mv_ep_reg   <= mv_ep_next;
            mv_dest_reg <= mv_dest_next;
            if (emit_s)
            begin
                out_valid_reg <= 1'b1;
                kind_reg      <= emit_kind_s;
                ep_out_reg    <= emit_ep_s;
                slot_reg      <= pptw_pkg::SLOT_OUT_W'(pos_reg);
                last_reg      <= emit_last_s;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < pptw_pkg::SLOT_COUNT; i++)
            begin
                head_reg[i] <= '0;
            end
        end
        else if (head_we_s)
        begin
            head_reg[head_waddr_s] <= head_wdata_s;
        end
    end

    always_ff @(posedge clk)
    begin
        if (link_we_s)
        begin
            link_reg[link_waddr_s] <= link_wdata_s;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < pptw_pkg::ENDPOINTS; i++)
            begin
                per_reg[i] <= '0;
            end
            queued_reg <= '0;
            stop_reg   <= '0;
        end
        else
        begin
            if (ins_we_s)
            begin
                per_reg[ep_idx_s]    <= q_item.slots;
                queued_reg[ep_idx_s] <= 1'b1;
                stop_reg[ep_idx_s]   <= 1'b0;
            end
            if (stop_we_s)
            begin
                stop_reg[ep_idx_s] <= 1'b1;
            end
            if (clr_we_s)
            begin
                per_reg[cur_idx_s]    <= '0;
                queued_reg[cur_idx_s] <= 1'b0;
                stop_reg[cur_idx_s]   <= 1'b0;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign kind         = kind_reg;
    assign endpoint_out = ep_out_reg;
    assign slot_out     = slot_reg;
    assign last         = last_reg;

    `PPTW_NEVER(a_pos_range, clk, rst_n, 32'(pos_reg) >= pptw_pkg::SLOT_COUNT)
    `PPTW_ASSERT(a_move_after_walk, clk, rst_n, state_reg == ST_MOVE |-> $past(state_reg) == ST_WALK)
    `PPTW_NEVER(a_guard_range, clk, rst_n, 32'(guard_reg) > pptw_pkg::ENDPOINTS)
    `PPTW_NEVER(a_stop_needs_queued, clk, rst_n, (stop_reg & ~queued_reg) != '0)

endmodule

// File: design/periodic_poll_timing_wheel_top.sv
// Top level of the periodic poll timing wheel: APB register, front end and back end.
// Depends on pptw_pkg, pptw_front and pptw_back.
//
//  Channel   Handshake             Payload
//  ------    --------------------  ----------------------------------------
//  in        in_valid / in_ready   cmd, endpoint, period_ms
//  out       out_valid / out_ready kind, endpoint_out, slot_out, last
//  apb       psel/penable/pready   paddr, pwrite, pwdata, prdata
//
// Start, reject and stop are handled from the idle state; a start or reject result
// is registered and visible the cycle after the queue entry is taken.
// A tick walks the current slot's list with a move step per re-inserted entry; the
// single write ports on slot heads and link table set one step per cycle, and a
// stalled output holds each step that emits. Reset clears heads, periods and flags
// at once with no clearing pass (links are not reset); the two-entry queue accepts until full.
module periodic_poll_timing_wheel_top (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [pptw_pkg::CMD_W-1:0]      cmd,
    input  logic [pptw_pkg::EP_W-1:0]       endpoint,
    input  logic [pptw_pkg::PERIOD_W-1:0]   period_ms,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [pptw_pkg::KIND_W-1:0]     kind,
    output logic [pptw_pkg::EP_W-1:0]       endpoint_out,
    output logic [pptw_pkg::SLOT_OUT_W-1:0] slot_out,
    output logic                            last,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [2:0]                      paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);

    localparam logic REG_ENDPOINT_COUNT = 1'b0;
    localparam logic [pptw_pkg::EP_W-1:0] EP_COUNT_RESET = pptw_pkg::EP_W'(16);

    logic [pptw_pkg::EP_W-1:0] ep_count_reg, ep_count_next;
    logic                      q_valid;
    pptw_pkg::q_item_t         q_item;
    logic                      q_pop;

    assign pready = 1'b1;

    always_comb
    begin
        ep_count_next = ep_count_reg;
        if (psel && penable && pwrite && (paddr[2] == REG_ENDPOINT_COUNT))
        begin
            ep_count_next = pwdata[pptw_pkg::EP_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ep_count_reg <= EP_COUNT_RESET;
        end
        else
        begin
            ep_count_reg <= ep_count_next;
        end
    end

    assign prdata = (paddr[2] == REG_ENDPOINT_COUNT) ? 32'(ep_count_reg) : '0;

    pptw_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .cmd       (cmd),
        .endpoint  (endpoint),
        .period_ms (period_ms),
        .ep_count  (ep_count_reg),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop)
    );

    pptw_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_item       (q_item),
        .q_pop        (q_pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .kind         (kind),
        .endpoint_out (endpoint_out),
        .slot_out     (slot_out),
        .last         (last)
    );

endmodule
